[hw/rtl/stk_pkg.sv]
// Shared types, codes and default constants for the sorted key table.
package stk_pkg;

  localparam int STK_DEPTH      = 64;
  localparam int STK_KEY_CHARS  = 8;
  localparam int STK_STAMP_BITS = 32;

  // Fixed field widths of the ports.
  localparam int OP_W    = 2;
  localparam int KEY_W   = 64;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_EV,
    ST_SRC_RD,
    ST_SRC_EV,
    ST_FINISH
  } stk_state_t;

  // Outcome of comparing a stored key with the request key.
  typedef struct packed {
    logic ge;
    logic eq;
  } stk_flags_t;

endpackage

[hw/rtl/stk_ram.sv]
// Generic simple dual-port RAM with a registered read.
module stk_ram
  import stk_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/stk_alu.sv]
// Shared key comparator and table pointer stepper.
module stk_alu
  import stk_pkg::*;
#(
  parameter int KEY_BITS = 64,
  parameter int PTR_W    = 7
) (
  input  logic [KEY_BITS-1:0] entry_key,
  input  logic [KEY_BITS-1:0] req_key,
  input  logic [PTR_W-1:0]    ptr,
  output stk_flags_t          flags,
  output logic [PTR_W-1:0]    ptr_up,
  output logic [PTR_W-1:0]    ptr_dn
);

  // Keys compare as unsigned words, which matches the order of the strings.
  always_comb begin
    flags.ge = (entry_key >= req_key);
    flags.eq = (entry_key == req_key);
  end

  assign ptr_up = ptr + PTR_W'(1);
  assign ptr_dn = ptr - PTR_W'(1);

endmodule

[hw/rtl/sorted_key_table_unit.sv]
// Top level of the sorted key table: sequencer, request and result registers.
//
// The block keeps up to DEPTH entries sorted ascending by key, each with a
// timestamp, in one simple dual-port RAM. Request words (op, key, stamp) come
// in on the req channel and are taken at an edge with req_valid high and
// req_stall low; one result word (ok, occupied, free_places) per request
// leaves on the rsp channel and is taken with rsp_valid high and rsp_stall low.
// The user must write the capacity register through cfg_wen and cfg_wdata only
// while idle; the block itself does not enforce this.
//
// Each table step is a RAM read followed by a compare. An insert walks down
// from the free place above the top entry, moving up each entry that is not
// smaller; a refused insert or the spare op code goes straight to the finish
// state. Remove and lookup walk up from entry 0. The req channel is stalled
// until the result is loaded.
// A finished result sits in the rsp register, so the next request is taken
// while it waits; a later result is held in the sequencer until the register
// frees. Reset empties the table without touching the RAM, sets capacity to
// 64 and leaves both channels idle.
module sorted_key_table_unit
  import stk_pkg::*;
#(
  parameter int DEPTH      = STK_DEPTH,
  parameter int KEY_CHARS  = STK_KEY_CHARS,
  parameter int STAMP_BITS = STK_STAMP_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [OP_W-1:0]    op,
  input  logic [KEY_W-1:0]   key,
  input  logic [STAMP_W-1:0] stamp,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               ok,
  output logic [CNT_W-1:0]   occupied,
  output logic [CNT_W-1:0]   free_places
);

  localparam int KEY_BITS    = 8 * KEY_CHARS;
  localparam int ENTRY_W     = KEY_BITS + STAMP_BITS;
  localparam int ADDR_W      = $clog2(DEPTH);
  // The count can never pass the smaller of DEPTH and the largest capacity.
  localparam int LIMIT_MAX_I = (DEPTH < 128) ? DEPTH : 127;
  localparam int PTR_W       = $clog2(LIMIT_MAX_I + 1);
  localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(LIMIT_MAX_I);

  stk_state_t state, state_next;
  logic [PTR_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             found, found_next;
  logic             res_ok, res_ok_next;
  logic [CNT_W-1:0] capacity;

  logic [OP_W-1:0]       req_op;
  logic [KEY_BITS-1:0]   req_key;
  logic [STAMP_BITS-1:0] req_stamp;

  logic [CNT_W-1:0] limit;
  logic             accept;
  logic             rsp_free;
  logic             rsp_load;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  stk_flags_t       flags;
  logic [PTR_W-1:0] ptr_up;
  logic [PTR_W-1:0] ptr_dn;

  assign limit     = (capacity < LIMIT_MAX) ? capacity : LIMIT_MAX;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = (state == ST_FINISH) && rsp_free;

  stk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stk_alu #(
    .KEY_BITS (KEY_BITS),
    .PTR_W    (PTR_W)
  ) u_alu (
    .entry_key (ram_rdata[ENTRY_W-1 -: KEY_BITS]),
    .req_key   (req_key),
    .ptr       (ptr),
    .flags     (flags),
    .ptr_up    (ptr_up),
    .ptr_dn    (ptr_dn)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_INSERT: state_next = (count >= limit) ? ST_FINISH : ST_INS_RD;
            OP_REMOVE: state_next = ST_SRC_RD;
            OP_LOOKUP: state_next = ST_SRC_RD;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_INS_RD: state_next = (ptr == '0) ? ST_FINISH : ST_INS_EV;
      ST_INS_EV: state_next = flags.ge ? ST_INS_RD : ST_FINISH;
      ST_SRC_RD: state_next = (CNT_W'(ptr) == count) ? ST_FINISH : ST_SRC_EV;
      ST_SRC_EV: begin
        if (!found && flags.eq && (req_op == OP_LOOKUP)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SRC_RD;
        end
      end
      ST_FINISH: state_next = rsp_free ? ST_IDLE : ST_FINISH;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory controls and datapath updates for each state.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = ADDR_W'(ptr);
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ADDR_W'(ptr);
    ptr_next    = ptr;
    count_next  = count;
    found_next  = found;
    res_ok_next = res_ok;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          // Insert walks down from the free place above the top entry.
          ptr_next    = (op == OP_INSERT) ? PTR_W'(count) : '0;
          found_next  = 1'b0;
          res_ok_next = 1'b0;
        end
      end
      ST_INS_RD: begin
        if (ptr == '0) begin
          ram_we      = 1'b1;
          ram_waddr   = '0;
          ram_wdata   = {req_key, req_stamp};
          count_next  = count + CNT_W'(1);
          res_ok_next = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(ptr_dn);
        end
      end
      ST_INS_EV: begin
        ram_we = 1'b1;
        if (flags.ge) begin
          // Entry below is not smaller: move it up into the hole.
          ptr_next = ptr_dn;
        end else begin
          ram_wdata   = {req_key, req_stamp};
          count_next  = count + CNT_W'(1);
          res_ok_next = 1'b1;
        end
      end
      ST_SRC_RD: begin
        if (CNT_W'(ptr) == count) begin
          if (found) begin
            count_next  = count - CNT_W'(1);
            res_ok_next = 1'b1;
          end
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_SRC_EV: begin
        if (found) begin
          // Removal under way: each later entry drops one place.
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(ptr_dn);
          ptr_next  = ptr_up;
        end else if (flags.eq) begin
          found_next = 1'b1;
          if (req_op == OP_LOOKUP) begin
            res_ok_next = 1'b1;
          end else begin
            ptr_next = ptr_up;
          end
        end else begin
          ptr_next = ptr_up;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      count     <= '0;
      found     <= 1'b0;
      res_ok    <= 1'b0;
      capacity  <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      ptr    <= ptr_next;
      count  <= count_next;
      found  <= found_next;
      res_ok <= res_ok_next;
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request and result words; only the top KEY_CHARS bytes of a key count.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= op;
      req_key   <= key[KEY_W-1 -: KEY_BITS];
      req_stamp <= STAMP_BITS'(stamp);
    end
    if (rsp_load) begin
      ok          <= res_ok;
      occupied    <= count;
      free_places <= (capacity > count) ? (capacity - count) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("sequencer did not start after a request was taken");

  a_ins_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_EV) |-> (ptr != '0))
    else $error("insert compare reached with no entry below the hole");

  a_src_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRC_EV) |-> (CNT_W'(ptr) < count))
    else $error("search compare beyond the held entries");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= LIMIT_MAX)
    else $error("entry count exceeds the table size");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> (rsp_valid && (state == ST_IDLE)))
    else $error("result word not presented after finishing");
`endif

endmodule

[test/tb_sorted_key_table_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sorted key table unit: directed and random table traffic.
module tb_sorted_key_table_unit;
  import stk_pkg::*;

  // Op code 3 has no meaning in the package, but the port can carry it, so it is sent too.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Only the top KEY_CHARS bytes of a key take part in the comparison.
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * STK_KEY_CHARS);

  // The slowest operation walks the whole table once, a RAM read and a compare a step.
  localparam int WALK_CYCLES    = 2 * STK_DEPTH + 3;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 20 * WALK_CYCLES;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] occupied;
    logic [CNT_W-1:0] free_places;
  } table_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata = '0;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [OP_W-1:0]    op = OP_LOOKUP;
  logic [KEY_W-1:0]   key = '0;
  logic [STAMP_W-1:0] stamp = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic               ok;
  logic [CNT_W-1:0]   occupied;
  logic [CNT_W-1:0]   free_places;

  // Our own view of the table: the keys held, in ascending order, and the capacity.
  // Stamps never reach the result word, so they are not kept.
  logic [KEY_W-1:0] held_keys[$];
  logic [CNT_W-1:0] table_capacity = CAP_RESET;

  // Result words still owed by the block, oldest first.
  table_result_t pending_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int          quiet_cycles = 0;

  sorted_key_table_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .op          (op),
    .key         (key),
    .stamp       (stamp),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .ok          (ok),
    .occupied    (occupied),
    .free_places (free_places)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one operation to our copy of the table and returns the result word it should
  // produce. An insert goes in front of the first key that is not smaller, so a duplicate
  // lands ahead of its equals; a remove takes out the first equal key only.
  function automatic table_result_t predict_table_op(input logic [OP_W-1:0] o,
                                                     input logic [KEY_W-1:0] raw_key);
    logic [KEY_W-1:0] k;
    int unsigned      limit;
    int unsigned      pos;
    int               hit;
    table_result_t    r;
    k = raw_key & KEY_MASK;
    limit = (table_capacity < STK_DEPTH) ? table_capacity : STK_DEPTH;
    r.ok = 1'b0;
    hit = -1;
    for (int i = 0; i < held_keys.size(); i++) begin
      if (hit < 0 && held_keys[i] == k) hit = i;
    end
    case (o)
      OP_INSERT: begin
        // A full table, or a capacity already at or below the count, refuses the insert.
        if (held_keys.size() < limit) begin
          pos = 0;
          while (pos < held_keys.size() && held_keys[pos] < k) pos++;
          held_keys.insert(pos, k);
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          held_keys.delete(hit);
          r.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        r.ok = (hit >= 0);
      end
      default: begin
        // The spare code changes nothing and only reports the counts.
      end
    endcase
    r.occupied = CNT_W'(held_keys.size());
    // Free places never go negative, even when the capacity is lowered below the count.
    r.free_places = (table_capacity > held_keys.size()) ?
                    CNT_W'(table_capacity - held_keys.size()) : '0;
    return r;
  endfunction

  // Chooses a key: often one already held so that removes and lookups find something,
  // sometimes a short plate from a tiny alphabet so that duplicates and shared prefixes
  // are common, and otherwise a key with every bit random.
  function automatic logic [KEY_W-1:0] pick_key(input int unsigned held_pct);
    logic [KEY_W-1:0] k;
    int unsigned      roll;
    int unsigned      len;
    roll = $urandom_range(99);
    k = '0;
    if (roll < held_pct && held_keys.size() != 0) begin
      k = held_keys[$urandom_range(held_keys.size() - 1)];
    end else if (roll < held_pct + (100 - held_pct) / 2) begin
      len = $urandom_range(3, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(2))
          0: k[KEY_W-1-8*i -: 8] = "A";
          1: k[KEY_W-1-8*i -: 8] = "B";
          default: k[KEY_W-1-8*i -: 8] = "1";
        endcase
      end
    end else begin
      k = {$urandom(), $urandom()};
    end
    return k;
  endfunction

  // Offers one request word and waits until the block takes it. Valid is only lowered when
  // the sender decides to idle before this word, so back-to-back words keep it high.
  task automatic send_word(input logic [OP_W-1:0] o, input logic [KEY_W-1:0] k,
                           input logic [STAMP_W-1:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    op        <= o;
    key       <= k;
    stamp     <= s;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_table_op(o, k));
  endtask

  // Stops sending until every owed result word has come back. The queue is looked at on the
  // falling edge, where it cannot be changing, and the task returns on a rising edge.
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  // The capacity register is only written while the block is idle.
  task automatic set_capacity(input logic [CNT_W-1:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    table_capacity = value;
  endtask

  // A run of random words. About one word in twenty-five uses the spare op code; the rest
  // split between insert, remove and lookup by the given shares.
  task automatic run_mix(input int unsigned n, input int unsigned insert_pct,
                         input int unsigned remove_pct, input int unsigned held_pct);
    logic [OP_W-1:0] o;
    int unsigned     roll;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) o = OP_SPARE;
      else begin
        roll = $urandom_range(99);
        if (roll < insert_pct) o = OP_INSERT;
        else if (roll < insert_pct + remove_pct) o = OP_REMOVE;
        else o = OP_LOOKUP;
      end
      send_word(o, pick_key(held_pct), $urandom());
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(199) == 0) hold_until_drained();
    end
  endtask

  // Empty-table answers, the extreme keys and stamps, duplicates and every op code.
  task automatic test_empty_table_and_extremes();
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_REMOVE, '1, '0);
    send_word(OP_SPARE, '1, '1);
    send_word(OP_INSERT, '1, '1);
    send_word(OP_INSERT, '0, '0);
    send_word(OP_INSERT, {"AB1", 40'd0}, 32'h5555_5555);
    send_word(OP_INSERT, {"AB1", 40'd0}, 32'hAAAA_AAAA);
    send_word(OP_LOOKUP, {"AB1", 40'd0}, '0);
    send_word(OP_LOOKUP, {"AB2", 40'd0}, '1);
    send_word(OP_REMOVE, {"AB1", 40'd0}, '0);
    send_word(OP_REMOVE, {"AB1", 40'd0}, '0);
    send_word(OP_REMOVE, {"AB1", 40'd0}, '0);
    send_word(OP_REMOVE, '1, '0);
    send_word(OP_SPARE, '0, '0);
    hold_until_drained();
  endtask

  // A capacity small enough to fill, a capacity lowered below the count, and zero.
  task automatic test_capacity_limits();
    set_capacity(7'd2);
    send_word(OP_INSERT, 64'h0123_4567_89AB_CDEF, 32'h0000_FFFF);
    send_word(OP_INSERT, 64'hFEDC_BA98_7654_3210, 32'hFFFF_0000);
    set_capacity(7'd1);
    send_word(OP_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0001);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_REMOVE, 64'h0123_4567_89AB_CDEF, '0);
    set_capacity(7'd0);
    send_word(OP_REMOVE, '0, '0);
    send_word(OP_INSERT, 64'h0000_0000_0000_0001, '1);
    send_word(OP_LOOKUP, '0, '0);
    set_capacity(CAP_RESET);
  endtask

  // Fill the table to its full depth with mostly inserts, keep knocking on it while full,
  // then drain it again with mostly removes of held keys.
  task automatic test_fill_to_depth();
    set_capacity(CNT_W'(STK_DEPTH));
    run_mix(120, 85, 8, 45);
    run_mix(110, 10, 70, 90);
  endtask

  // Capacity moved around under a partly filled table, down to zero and back to full.
  task automatic test_capacity_changes();
    set_capacity(CNT_W'($urandom_range(STK_DEPTH - 1, 1)));
    run_mix(40, 60, 20, 50);
    set_capacity(CNT_W'($urandom_range(20, 0)));
    run_mix(25, 50, 30, 60);
    set_capacity(7'd0);
    run_mix(15, 50, 30, 60);
    set_capacity(CNT_W'(STK_DEPTH));
    run_mix(35, 40, 40, 60);
  endtask

  // Result checker and receiver. Each word taken is compared field by field with the oldest
  // expectation; the stall for the next edge is drawn afresh every cycle.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: ok %0d occupied %0d free_places %0d",
               ok, occupied, free_places);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok);
          mismatches++;
        end
        if (occupied !== want.occupied) begin
          $error("occupied: expected %0d, got %0d", want.occupied, occupied);
          mismatches++;
        end
        if (free_places !== want.free_places) begin
          $error("free_places: expected %0d, got %0d", want.free_places, free_places);
          mismatches++;
        end
      end
    end
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: a long stretch in which no word moves on either channel means a hang.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Three idling patterns: the receiver holding back most, then the sender, then
    // neither, so that gaps land on every stage of the walk and the shifts.
    for (int pattern = 0; pattern < 3; pattern++) begin
      case (pattern)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (pattern == 0) begin
        test_empty_table_and_extremes();
        test_capacity_limits();
      end
      test_fill_to_depth();
      test_capacity_changes();
    end

    hold_until_drained();
    // Any stray word after the last expected one still has a full walk's time to show up.
    repeat (WALK_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
